// ===== src/ant_pkg.sv =====
// ----------------------------------------------------------------------------
// ant_pkg: shared types and constants for the aging neighbor table
// Table geometry, entry layout, result codes and sequencer states.
// ----------------------------------------------------------------------------
package ant_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd3;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD_SCAN,
    S_UPD_DONE,
    S_TICK_AGE,
    S_TICK_CHECK,
    S_TICK_LIST
  } state_t;

  typedef struct packed {
    logic [63:0] client_hi;
    logic [63:0] client_lo;
    logic [63:0] parent_hi;
    logic [63:0] parent_lo;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

  // slot index as reported: low 4 bits, zero extended for small tables
  function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] tmp;
    tmp = {4'b0000, s};
    return tmp[3:0];
  endfunction

endpackage

// ===== src/aging_neighbor_table.sv =====
// ----------------------------------------------------------------------------
// aging_neighbor_table: client-to-parent address table with aging
// Sequencer that scans the table one slot per cycle through a shared
// compare unit and a single-port-read entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_* and raise start; the beat is taken at a clock
//   edge with start high and busy low. busy stays high while the item works.
//   in_func 0 updates or inserts a client/parent pair, 1 is a minute tick.
//   Results: out_valid marks each result beat for one cycle; the receiver
//   cannot stall, so every beat must be captured when it is shown.
//   An update gives one reply beat (one slot compared per cycle, early stop
//   on a match). A tick runs an aging pass and a check step, then, if any
//   slot is still valid, a listing pass that shows one beat per valid slot,
//   in slot order; if none is left, it shows one empty beat instead. The
//   rate is set by the one RAM read port and the shared compare unit, one
//   slot per cycle.
//   Configuration: cfg_we writes the timeout (cfg_wdata); the user must
//   write it only while idle, as the block does not enforce this.
//   Reset: all slots invalid, minute count zero, timeout 3. No clearing pass.
// ----------------------------------------------------------------------------
module aging_neighbor_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [63:0] in_client_addr_hi,
  input  logic [63:0] in_client_addr_lo,
  input  logic [63:0] in_parent_addr_hi,
  input  logic [63:0] in_parent_addr_lo,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [63:0] out_client_hi,
  output logic [63:0] out_client_lo,
  output logic [63:0] out_parent_hi,
  output logic [63:0] out_parent_lo,
  output logic        out_last
);
  import ant_pkg::*;

  state_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]        scan_r, scan_nxt;
  logic                     issue_r, issue_nxt;
  logic                     cmp_en_r, cmp_en_nxt;
  logic [SLOT_W-1:0]        cmp_slot_r, cmp_slot_nxt;
  logic                     hit_r, hit_nxt;
  logic [SLOT_W-1:0]        hit_slot_r, hit_slot_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]        free_slot_r, free_slot_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]              minute_r, minute_nxt;
  logic [7:0]               timeout_r, timeout_nxt;

  logic [63:0] item_ch_r, item_ch_nxt;
  logic [63:0] item_cl_r, item_cl_nxt;
  logic [63:0] item_ph_r, item_ph_nxt;
  logic [63:0] item_pl_r, item_pl_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [63:0] out_ch_r, out_ch_nxt;
  logic [63:0] out_cl_r, out_cl_nxt;
  logic [63:0] out_ph_r, out_ph_nxt;
  logic [63:0] out_pl_r, out_pl_nxt;
  logic        out_last_r, out_last_nxt;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd_ent;
  cmp_res_t          cmp_res;

  logic                     scanning;
  logic                     cur_valid;
  logic [TABLE_ENTRIES-1:0] higher;
  logic                     more_after;

  ant_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (rd_ent)
  );

  ant_match u_match (
    .ent     (rd_ent),
    .key_hi  (item_ch_r),
    .key_lo  (item_cl_r),
    .minute  (minute_r),
    .timeout (timeout_r),
    .res     (cmp_res)
  );

  assign scanning  = (state_r == S_UPD_SCAN) || (state_r == S_TICK_AGE) ||
                     (state_r == S_TICK_LIST);
  assign cur_valid = valid_r[cmp_slot_r];

  // any valid slot above the one being listed
  always_comb begin
    for (int j = 0; j < TABLE_ENTRIES; j++) begin
      higher[j] = valid_r[j] && (SLOT_W'(j) > cmp_slot_r);
    end
  end
  assign more_after = |higher;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    issue_nxt      = issue_r;
    cmp_en_nxt     = scanning && issue_r;
    cmp_slot_nxt   = scan_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    valid_nxt      = valid_r;
    minute_nxt     = minute_r;
    timeout_nxt    = cfg_we ? cfg_wdata : timeout_r;
    item_ch_nxt    = item_ch_r;
    item_cl_nxt    = item_cl_r;
    item_ph_nxt    = item_ph_r;
    item_pl_nxt    = item_pl_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ch_nxt     = out_ch_r;
    out_cl_nxt     = out_cl_r;
    out_ph_nxt     = out_ph_r;
    out_pl_nxt     = out_pl_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_slot_r;
    ram_wdata      = '{client_hi: item_ch_r, client_lo: item_cl_r,
                       parent_hi: item_ph_r, parent_lo: item_pl_r,
                       stamp: minute_r};

    // read address runs one slot ahead of the compare stage
    if (scanning && issue_r) begin
      if (scan_r == LAST_SLOT) begin
        issue_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_ch_nxt    = in_client_addr_hi;
          item_cl_nxt    = in_client_addr_lo;
          item_ph_nxt    = in_parent_addr_hi;
          item_pl_nxt    = in_parent_addr_lo;
          scan_nxt       = '0;
          issue_nxt      = 1'b1;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          if (in_func == FUNC_TICK) begin
            minute_nxt = minute_r + 32'd1;
            state_nxt  = S_TICK_AGE;
          end else begin
            state_nxt = S_UPD_SCAN;
          end
        end
      end
      S_UPD_SCAN: begin
        if (cmp_en_r) begin
          if (cur_valid && cmp_res.match) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = cmp_slot_r;
            state_nxt    = S_UPD_DONE;
          end else begin
            if (!cur_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_slot_nxt  = cmp_slot_r;
            end
            if (cmp_slot_r == LAST_SLOT) begin
              state_nxt = S_UPD_DONE;
            end
          end
        end
      end
      S_UPD_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_REPLY;
        out_ch_nxt    = item_ch_r;
        out_cl_nxt    = item_cl_r;
        out_ph_nxt    = item_ph_r;
        out_pl_nxt    = item_pl_r;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
        priority if (hit_r) begin
          out_status_nxt = ST_UPDATED;
          out_slot_nxt   = slot_field(hit_slot_r);
          ram_we         = 1'b1;
          ram_waddr      = hit_slot_r;
        end else if (free_found_r) begin
          out_status_nxt         = ST_INSERTED;
          out_slot_nxt           = slot_field(free_slot_r);
          ram_we                 = 1'b1;
          ram_waddr              = free_slot_r;
          valid_nxt[free_slot_r] = 1'b1;
        end else begin
          out_status_nxt = ST_DROPPED;
          out_slot_nxt   = 4'd0;
        end
      end
      S_TICK_AGE: begin
        if (cmp_en_r) begin
          if (cur_valid && cmp_res.expired) begin
            valid_nxt[cmp_slot_r] = 1'b0;
          end
          if (cmp_slot_r == LAST_SLOT) begin
            state_nxt = S_TICK_CHECK;
          end
        end
      end
      S_TICK_CHECK: begin
        if (valid_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_EMPTY;
          out_status_nxt = ST_UPDATED;
          out_slot_nxt   = 4'd0;
          out_ch_nxt     = '0;
          out_cl_nxt     = '0;
          out_ph_nxt     = '0;
          out_pl_nxt     = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          scan_nxt  = '0;
          issue_nxt = 1'b1;
          state_nxt = S_TICK_LIST;
        end
      end
      S_TICK_LIST: begin
        if (cmp_en_r) begin
          if (cur_valid) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_ENTRY;
            out_status_nxt = ST_UPDATED;
            out_slot_nxt   = slot_field(cmp_slot_r);
            out_ch_nxt     = rd_ent.client_hi;
            out_cl_nxt     = rd_ent.client_lo;
            out_ph_nxt     = rd_ent.parent_hi;
            out_pl_nxt     = rd_ent.parent_lo;
            out_last_nxt   = !more_after;
          end
          if (cmp_slot_r == LAST_SLOT) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_r      <= 1'b0;
      cmp_en_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      minute_r     <= '0;
      timeout_r    <= TIMEOUT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      cmp_en_r     <= cmp_en_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      valid_r      <= valid_nxt;
      minute_r     <= minute_nxt;
      timeout_r    <= timeout_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    cmp_slot_r   <= cmp_slot_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    item_ch_r    <= item_ch_nxt;
    item_cl_r    <= item_cl_nxt;
    item_ph_r    <= item_ph_nxt;
    item_pl_r    <= item_pl_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ch_r     <= out_ch_nxt;
    out_cl_r     <= out_cl_nxt;
    out_ph_r     <= out_ph_nxt;
    out_pl_r     <= out_pl_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_client_hi = out_ch_r;
  assign out_client_lo = out_cl_r;
  assign out_parent_hi = out_ph_r;
  assign out_parent_lo = out_pl_r;
  assign out_last      = out_last_r;

  // an accepted beat always starts a sequence
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a non-final beat means more listing beats are still coming
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && (state_r == S_TICK_LIST))
    else $error("non-final beat with no listing in progress");

  // insertion only goes into a free slot
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD_DONE) && !hit_r && free_found_r |-> !valid_r[free_slot_r])
    else $error("insert into occupied slot");

  // empty listing only when nothing survived aging
  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EMPTY) |-> out_last && (valid_r == '0))
    else $error("empty listing with valid entries");

endmodule

// ===== src/ant_ram.sv =====
// ----------------------------------------------------------------------------
// ant_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ant_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ant_match.sv =====
// ----------------------------------------------------------------------------
// ant_match: shared compare unit
// Client address match and age-against-timeout check for one stored entry.
// ----------------------------------------------------------------------------
module ant_match (
  input  ant_pkg::entry_t   ent,
  input  logic [63:0]       key_hi,
  input  logic [63:0]       key_lo,
  input  logic [31:0]       minute,
  input  logic [7:0]        timeout,
  output ant_pkg::cmp_res_t res
);
  import ant_pkg::*;

  logic [31:0] age;

  // age wraps mod 2^32 along with the minute counter
  assign age         = minute - ent.stamp;
  assign res.match   = (ent.client_hi == key_hi) && (ent.client_lo == key_lo);
  assign res.expired = (age >= {24'b0, timeout});

endmodule
